>>> src/bisr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bisection root finder.
package bisr_pkg;

	localparam int X_WIDTH_DEF   = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_FRAC     = 16;
	localparam int RHS_W         = 61;
	localparam int ADDR_W        = 4;
	localparam int CFG_W         = 32;

	localparam logic [7:0]              MAX_ITER_RST = 8'd99;
	localparam logic [15:0]             TOL_RST      = 16'd3;
	localparam logic signed [CFG_W-1:0] C1_RST       = 32'sd1638;
	localparam logic signed [CFG_W-1:0] C0_RST       = -32'sd262144;

	typedef enum logic [1:0] {
		REG_MAX_ITER = 2'd0,
		REG_TOL      = 2'd1,
		REG_C1       = 2'd2,
		REG_C0       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_CONV  = 2'd0,
		STAT_LIMIT = 2'd1,
		STAT_NOBR  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_A,
		S_EV_A,
		S_MUL_B,
		S_EV_B,
		S_MUL_M,
		S_EV_M
	} state_t;

	typedef struct packed {
		logic [7:0]              max_iter;
		logic [15:0]             tol;
		logic signed [CFG_W-1:0] c1;
		logic signed [CFG_W-1:0] c0;
	} cfg_t;

	typedef struct packed {
		logic pos;
		logic neg;
		logic below_tol;
	} fsign_t;

endpackage

>>> src/bisection_root_finder.sv
`timescale 1ns / 1ps
// Top level: bisection sequencer around the shared f evaluator and register file.
//
// Usage: write max_iterations, tolerance, coeff_linear and coeff_const over the
// APB port while the block is idle (byte addresses 0, 4, 8, 12). Pulse start with
// lower_end/upper_end while busy is low; the word is taken at that edge and busy
// rises. The block evaluates f at both ends and, unless both give the same sign,
// halves the interval, each halving being one pass through the evaluator: the
// registered products, then sum, sign test and update.
// One result word appears on root_estimate, halves_used and status for exactly
// one cycle with done high; busy falls in that same cycle, so a new start may
// be given there. Results cannot be stalled by the receiver. Reset clears the
// sequencer and loads the register defaults; an item in flight is dropped.
module bisection_root_finder #(
	parameter int X_WIDTH   = bisr_pkg::X_WIDTH_DEF,
	parameter int FRAC_BITS = bisr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bisr_pkg::ADDR_W-1:0]   paddr,
	input  logic [bisr_pkg::CFG_W-1:0]    pwdata,
	output logic [bisr_pkg::CFG_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [X_WIDTH-1:0]     lower_end,
	input  logic signed [X_WIDTH-1:0]     upper_end,
	output logic                          done,
	output logic signed [X_WIDTH-1:0]     root_estimate,
	output logic [7:0]                    halves_used,
	output logic [1:0]                    status
);

	localparam int LHS_W = X_WIDTH + 1 + bisr_pkg::COEF_FRAC;
	localparam int RW    = bisr_pkg::RHS_W;
	localparam logic [RW-1:0] RHS_CAP = RW'(1) << (RW - 1);

	bisr_pkg::cfg_t     cfg;
	bisr_pkg::fsign_t   fl;
	bisr_pkg::state_t   state_q;
	bisr_pkg::state_t   state_d;
	bisr_pkg::status_t  fin_status;

	logic signed [X_WIDTH-1:0] a_q;
	logic signed [X_WIDTH-1:0] b_q;
	logic signed [X_WIDTH-1:0] x_q;
	logic                      fa_pos_q;
	logic                      fa_neg_q;
	logic signed [LHS_W-1:0]   lhs_q;
	logic [RW-1:0]             rhs_q;
	logic [7:0]                p_q;
	logic [7:0]                lim_q;
	logic                      done_q;
	logic signed [X_WIDTH-1:0] root_q;
	logic [7:0]                halves_q;
	logic [1:0]                status_q;

	logic signed [X_WIDTH:0]   sum_ab;
	logic signed [X_WIDTH:0]   sum_xb;
	logic signed [X_WIDTH:0]   sum_ax;
	logic signed [X_WIDTH:0]   diff_in;
	logic signed [X_WIDTH-1:0] mid_ab;
	logic signed [X_WIDTH-1:0] nxt_mid;
	logic                      same_sign;
	logic [8:0]                p_inc;
	logic [RW-1:0]             rhs_dbl;
	logic [RW-1:0]             rhs_nx;
	logic                      wide_ok;
	logic                      conv;
	logic                      at_lim;
	logic                      finish;

	bisr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bisr_eval #(
		.X_WIDTH   (X_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_eval (
		.clk (clk),
		.x   (x_q),
		.c1  (cfg.c1),
		.c0  (cfg.c0),
		.tol (cfg.tol),
		.fl  (fl)
	);

	// midpoints: floor of half the exact sum is the upper bits of that sum
	always_comb begin
		sum_ab  = {a_q[X_WIDTH-1], a_q} + {b_q[X_WIDTH-1], b_q};
		sum_xb  = {x_q[X_WIDTH-1], x_q} + {b_q[X_WIDTH-1], b_q};
		sum_ax  = {a_q[X_WIDTH-1], a_q} + {x_q[X_WIDTH-1], x_q};
		diff_in = {upper_end[X_WIDTH-1], upper_end} - {lower_end[X_WIDTH-1], lower_end};
		mid_ab  = sum_ab[X_WIDTH:1];
		// fa holds the sign at the left end; in S_EV_B the flags are f at the right end
		same_sign = (fa_pos_q & fl.pos) | (fa_neg_q & fl.neg);
		nxt_mid   = same_sign ? sum_xb[X_WIDTH:1] : sum_ax[X_WIDTH:1];
		p_inc     = {1'b0, p_q} + 9'd1;
		rhs_dbl   = rhs_q << 1;
		if (rhs_q >= RHS_CAP || rhs_dbl > RHS_CAP) begin
			rhs_nx = RHS_CAP;
		end else begin
			rhs_nx = rhs_dbl;
		end
		wide_ok = lhs_q[LHS_W-1] || ({{(RW-LHS_W){1'b0}}, lhs_q} < rhs_nx);
		conv    = fl.below_tol & wide_ok;
		at_lim  = p_inc >= {1'b0, lim_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bisr_pkg::S_IDLE:  begin
				if (start) begin
					state_d = bisr_pkg::S_MUL_A;
				end
			end
			bisr_pkg::S_MUL_A: state_d = bisr_pkg::S_EV_A;
			bisr_pkg::S_EV_A:  state_d = bisr_pkg::S_MUL_B;
			bisr_pkg::S_MUL_B: state_d = bisr_pkg::S_EV_B;
			bisr_pkg::S_EV_B:  state_d = same_sign ? bisr_pkg::S_IDLE : bisr_pkg::S_MUL_M;
			bisr_pkg::S_MUL_M: state_d = bisr_pkg::S_EV_M;
			bisr_pkg::S_EV_M:  state_d = (conv | at_lim) ? bisr_pkg::S_IDLE : bisr_pkg::S_MUL_M;
			default:           state_d = bisr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		finish     = 1'b0;
		fin_status = bisr_pkg::STAT_LIMIT;
		case (state_q)
			bisr_pkg::S_EV_B: begin
				finish     = same_sign;
				fin_status = bisr_pkg::STAT_NOBR;
			end
			bisr_pkg::S_EV_M: begin
				finish     = conv | at_lim;
				fin_status = conv ? bisr_pkg::STAT_CONV : bisr_pkg::STAT_LIMIT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bisr_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bisr_pkg::S_IDLE: begin
				if (start) begin
					a_q   <= lower_end;
					b_q   <= upper_end;
					x_q   <= lower_end;
					p_q   <= 8'd0;
					lim_q <= (cfg.max_iter == 8'd0) ? 8'd1 : cfg.max_iter;
					lhs_q <= {diff_in, {bisr_pkg::COEF_FRAC{1'b0}}};
					rhs_q <= RW'(cfg.tol) << FRAC_BITS;
				end
			end
			bisr_pkg::S_EV_A: begin
				fa_pos_q <= fl.pos;
				fa_neg_q <= fl.neg;
				x_q      <= b_q;
			end
			bisr_pkg::S_EV_B: begin
				x_q <= mid_ab;
			end
			bisr_pkg::S_EV_M: begin
				// keep the half whose ends differ in sign
				if (same_sign) begin
					a_q      <= x_q;
					fa_pos_q <= fl.pos;
					fa_neg_q <= fl.neg;
				end else begin
					b_q <= x_q;
				end
				x_q   <= nxt_mid;
				p_q   <= p_inc[7:0];
				rhs_q <= rhs_nx;
			end
			default: ;
		endcase
		if (finish) begin
			status_q <= fin_status;
			if (state_q == bisr_pkg::S_EV_B) begin
				root_q   <= '0;
				halves_q <= 8'd0;
			end else begin
				root_q   <= nxt_mid;
				halves_q <= p_inc[7:0];
			end
		end
	end

	assign busy          = (state_q != bisr_pkg::S_IDLE);
	assign done          = done_q;
	assign root_estimate = root_q;
	assign halves_used   = halves_q;
	assign status        = status_q;

endmodule

>>> src/bisr_cfg.sv
`timescale 1ns / 1ps
// APB register file holding the iteration limit, tolerance and coefficients.
module bisr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bisr_pkg::ADDR_W-1:0]   paddr,
	input  logic [bisr_pkg::CFG_W-1:0]    pwdata,
	output logic [bisr_pkg::CFG_W-1:0]    prdata,
	output logic                          pready,
	output bisr_pkg::cfg_t                cfg
);

	bisr_pkg::cfg_t   cfg_q;
	bisr_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = bisr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iter <= bisr_pkg::MAX_ITER_RST;
			cfg_q.tol      <= bisr_pkg::TOL_RST;
			cfg_q.c1       <= bisr_pkg::C1_RST;
			cfg_q.c0       <= bisr_pkg::C0_RST;
		end else if (wr_en) begin
			case (idx)
				bisr_pkg::REG_MAX_ITER: cfg_q.max_iter <= pwdata[7:0];
				bisr_pkg::REG_TOL:      cfg_q.tol      <= pwdata[15:0];
				bisr_pkg::REG_C1:       cfg_q.c1       <= $signed(pwdata);
				bisr_pkg::REG_C0:       cfg_q.c0       <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bisr_pkg::REG_MAX_ITER: prdata = {24'd0, cfg_q.max_iter};
			bisr_pkg::REG_TOL:      prdata = {16'd0, cfg_q.tol};
			bisr_pkg::REG_C1:       prdata = cfg_q.c1;
			bisr_pkg::REG_C0:       prdata = cfg_q.c0;
			default:                prdata = '0;
		endcase
	end

endmodule

>>> src/bisr_eval.sv
`timescale 1ns / 1ps
// Shared evaluator of f(x) = x*x + c1*x + c0: registered products, then sign and size flags.
module bisr_eval #(
	parameter int X_WIDTH   = bisr_pkg::X_WIDTH_DEF,
	parameter int FRAC_BITS = bisr_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic signed [X_WIDTH-1:0]          x,
	input  logic signed [bisr_pkg::CFG_W-1:0]  c1,
	input  logic signed [bisr_pkg::CFG_W-1:0]  c0,
	input  logic [15:0]                        tol,
	output bisr_pkg::fsign_t                   fl
);

	localparam int SQ_W  = 2 * X_WIDTH;
	localparam int LIN_W = bisr_pkg::CFG_W + X_WIDTH;
	localparam int PW    = (SQ_W > LIN_W) ? SQ_W : LIN_W;
	localparam int SUM_W = PW + 2;
	localparam int SQ_SH = 2 * FRAC_BITS - bisr_pkg::COEF_FRAC;

	logic signed [SQ_W-1:0]  sq_s1;
	logic signed [LIN_W-1:0] lin_s1;
	logic signed [SUM_W-1:0] sq_x;
	logic signed [SUM_W-1:0] lin_x;
	logic signed [SUM_W-1:0] c0_x;
	logic signed [SUM_W-1:0] tol_x;
	logic signed [SUM_W-1:0] f;

	always_ff @(posedge clk) begin
		sq_s1  <= x * x;
		lin_s1 <= LIN_W'(c1) * LIN_W'(x);
	end

	// arithmetic shifts round toward minus infinity
	always_comb begin
		sq_x   = SUM_W'(sq_s1 >>> SQ_SH);
		lin_x  = SUM_W'(lin_s1 >>> FRAC_BITS);
		c0_x   = SUM_W'(c0);
		tol_x  = SUM_W'($signed({1'b0, tol}));
		f      = sq_x + lin_x + c0_x;
		fl.pos       = ~f[SUM_W-1] & (f != '0);
		fl.neg       = f[SUM_W-1];
		fl.below_tol = (f < tol_x) && (f > -tol_x);
	end

endmodule

>>> src/bisr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the bisection root finder, bound to the top level.
module bisr_chk #(
	parameter int X_WIDTH = bisr_pkg::X_WIDTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [X_WIDTH-1:0] root_estimate,
	input logic [7:0]                halves_used,
	input logic [1:0]                status
);

	// an accepted word occupies the block on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// the block frees up exactly when a result word comes out
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) == done)
		else $error("busy release and result strobe out of step");

	a_nobr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == bisr_pkg::STAT_NOBR |-> halves_used == 8'd0 && root_estimate == '0)
		else $error("unbracketed result carries nonzero fields");

	a_halved: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == bisr_pkg::STAT_CONV || status == bisr_pkg::STAT_LIMIT)
			|-> halves_used != 8'd0)
		else $error("bracketed result reports no halving");

endmodule

bind bisection_root_finder bisr_chk #(.X_WIDTH(X_WIDTH)) u_bisr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.root_estimate (root_estimate),
	.halves_used   (halves_used),
	.status        (status)
);

>>> sim/bisection_root_finder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: bisection root search against a fixed-point quadratic predictor.
module bisection_root_finder_tb;
	import bisr_pkg::*;

	localparam int     XW             = X_WIDTH_DEF;
	localparam int     SQ_SHIFT       = 2 * FRAC_BITS_DEF - COEF_FRAC;
	localparam longint F_MAX          = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint WIDTH_CAP      = 64'sh1000_0000_0000_0000;
	localparam int     WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [XW-1:0] root;
		logic [7:0]           halves;
		status_t              stat;
	} root_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 psel          = 1'b0;
	logic                 penable       = 1'b0;
	logic                 pwrite        = 1'b0;
	logic [ADDR_W-1:0]    paddr         = '0;
	logic [CFG_W-1:0]     pwdata        = '0;
	logic [CFG_W-1:0]     prdata;
	logic                 pready;
	logic                 start         = 1'b0;
	logic                 busy;
	logic signed [XW-1:0] lower_end     = '0;
	logic signed [XW-1:0] upper_end     = '0;
	logic                 done;
	logic signed [XW-1:0] root_estimate;
	logic [7:0]           halves_used;
	logic [1:0]           status;

	// register shadow used by the predictor
	logic [7:0]           cfg_max_iter = MAX_ITER_RST;
	logic [15:0]          cfg_tol      = TOL_RST;
	logic signed [31:0]   cfg_c1       = C1_RST;
	logic signed [31:0]   cfg_c0       = C0_RST;

	root_result_t pending_roots[$];
	int           items_sent       = 0;
	int           results_seen     = 0;
	int           mismatch_count   = 0;
	int           settings_written = 0;
	int           quiet_cycles     = 0;
	bit           back_to_back     = 1'b0;

	bisection_root_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.lower_end     (lower_end),
		.upper_end     (upper_end),
		.done          (done),
		.root_estimate (root_estimate),
		.halves_used   (halves_used),
		.status        (status)
	);

	always #6 clk = ~clk;

	function automatic longint clamp_sum(input longint a, input longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > F_MAX)
			return F_MAX;
		if (s < -F_MAX)
			return -F_MAX;
		return s[63:0];
	endfunction

	function automatic longint quad_value(input longint x);
		longint sq;
		longint lin;
		sq  = (x * x) >>> SQ_SHIFT;
		lin = (longint'(cfg_c1) * x) >>> FRAC_BITS_DEF;
		return clamp_sum(clamp_sum(sq, lin), longint'(cfg_c0));
	endfunction

	function automatic bit same_sign(input longint p, input longint q);
		return (p > 0 && q > 0) || (p < 0 && q < 0);
	endfunction

	function automatic root_result_t predict_root(input logic signed [XW-1:0] lo,
	                                              input logic signed [XW-1:0] hi);
		root_result_t r;
		longint       a, b, mid, fa, fb, fm, tol, lhs, rhs;
		int unsigned  iter_cap, halves;
		bit           finished;
		a   = longint'(lo);
		b   = longint'(hi);
		fa  = quad_value(a);
		fb  = quad_value(b);
		tol = longint'(cfg_tol);
		lhs = (b - a) <<< COEF_FRAC;
		rhs = tol <<< FRAC_BITS_DEF;
		iter_cap = (cfg_max_iter == 8'd0) ? 1 : 32'(cfg_max_iter);
		r.root   = '0;
		r.halves = '0;
		r.stat   = STAT_NOBR;
		if (same_sign(fa, fb))
			return r;
		halves   = 0;
		finished = 1'b0;
		while (!finished) begin
			halves++;
			mid = (a + b) >>> 1;
			fm  = quad_value(mid);
			// keep the half whose ends still straddle a sign change
			if (same_sign(fa, fm)) begin
				a  = mid;
				fa = fm;
			end else begin
				b = mid;
			end
			if (rhs < WIDTH_CAP)
				rhs = rhs * 2;
			if (rhs > WIDTH_CAP)
				rhs = WIDTH_CAP;
			if ((fm < 0 ? -fm : fm) < tol && lhs < rhs) begin
				r.stat   = STAT_CONV;
				finished = 1'b1;
			end else if (halves >= iter_cap) begin
				r.stat   = STAT_LIMIT;
				finished = 1'b1;
			end
		end
		mid      = (a + b) >>> 1;
		r.root   = mid[XW-1:0];
		r.halves = halves[7:0];
		return r;
	endfunction

	// Write one register, then read it back through the same port.
	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MAX_ITER: cfg_max_iter = value[7:0];
			REG_TOL:      cfg_tol      = value[15:0];
			REG_C1:       cfg_c1       = value;
			default:      cfg_c0       = value;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MAX_ITER: mask = 32'h0000_00FF;
			REG_TOL:      mask = 32'h0000_FFFF;
			default:      mask = 32'hFFFF_FFFF;
		endcase
		if ((prdata & mask) !== (value & mask)) begin
			$error("prdata at %0d: expected %0h, got %0h", idx, value & mask, prdata & mask);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		// leave the port idle before the next transfer
		@(posedge clk);
	endtask

	// Drop start and hold until every accepted word has produced its result.
	task automatic wait_results_drained();
		start <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
	endtask

	task automatic write_setting(input logic [7:0] iters, input logic [15:0] tol,
	                             input logic [31:0] c1, input logic [31:0] c0);
		wait_results_drained();
		cfg_write(REG_MAX_ITER, {24'd0, iters});
		cfg_write(REG_TOL, {16'd0, tol});
		cfg_write(REG_C1, c1);
		cfg_write(REG_C0, c0);
		settings_written++;
	endtask

	task automatic send_interval(input logic signed [XW-1:0] lo,
	                             input logic signed [XW-1:0] hi);
		int unsigned gap;
		gap = back_to_back ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		lower_end <= lo;
		upper_end <= hi;
		do @(posedge clk); while (busy);
		pending_roots.push_back(predict_root(lo, hi));
		items_sent++;
	endtask

	always @(posedge clk) begin : check_roots
		root_result_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (pending_roots.size() == 0) begin
				$error("result word with nothing pending: root_estimate %0d", root_estimate);
				mismatch_count++;
			end else begin
				want = pending_roots.pop_front();
				if (root_estimate !== want.root) begin
					$error("root_estimate: expected %0d, got %0d", want.root, root_estimate);
					mismatch_count++;
				end
				if (halves_used !== want.halves) begin
					$error("halves_used: expected %0d, got %0d", want.halves, halves_used);
					mismatch_count++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bisection_root_finder_tb: FAIL");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_interval(24'sd0, 24'sd262144);
		send_interval(-24'sd262144, 24'sd0);
		send_interval(-24'sd8388608, 24'sd8388607);
		send_interval(24'sd0, 24'sd0);
		// reversed ends pass the width test on every halving
		send_interval(24'sd262144, 24'sd0);
		send_interval(24'sd8388607, -24'sd8388608);
	endtask

	task automatic test_limit_edges();
		write_setting(8'd0, TOL_RST, C1_RST, C0_RST);
		send_interval(24'sd0, 24'sd262144);
		write_setting(8'd1, TOL_RST, C1_RST, C0_RST);
		send_interval(24'sd0, 24'sd262144);
		// zero tolerance can never converge: run the full 255 halvings
		write_setting(8'd255, 16'd0, C1_RST, C0_RST);
		send_interval(-24'sd262144, 24'sd0);
	endtask

	task automatic test_exact_root();
		// f = x*x - 4 has an exact zero at 2.0
		write_setting(8'd99, 16'd3, 32'd0, -32'sd262144);
		send_interval(24'sd131072, 24'sd327680);
		send_interval(24'sd131072, 24'sd131072);
		send_interval(-24'sd131072, 24'sd131072);
	endtask

	task automatic test_last_halving();
		root_result_t probe;
		write_setting(8'd255, 16'd200, 32'd0, -32'sd131072);
		probe = predict_root(24'sd0, 24'sd262144);
		send_interval(24'sd0, 24'sd262144);
		if (probe.stat == STAT_CONV && probe.halves > 1) begin
			// limit equal to the converging halving, then one short of it
			write_setting(probe.halves, 16'd200, 32'd0, -32'sd131072);
			send_interval(24'sd0, 24'sd262144);
			write_setting(probe.halves - 8'd1, 16'd200, 32'd0, -32'sd131072);
			send_interval(24'sd0, 24'sd262144);
		end
	endtask

	task automatic test_coeff_extremes();
		write_setting(8'd255, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_interval(-24'sd8388608, 24'sd8388607);
		send_interval(24'sd0, 24'sd8388607);
		write_setting(8'd1, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_interval(24'sd8388607, -24'sd8388608);
	endtask

	task automatic test_random_roots();
		int                   r1, r2;
		logic [7:0]           iters;
		logic [15:0]          tol;
		logic [31:0]          c1, c0;
		longint               prod;
		logic signed [XW-1:0] lo, hi, tmp;
		for (int phase = 0; phase < 30; phase++) begin
			iters = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 48));
			case ($urandom_range(0, 2))
				0:       tol = 16'($urandom_range(0, 64));
				1:       tol = 16'($urandom_range(0, 65535));
				default: tol = 16'($urandom_range(256, 4096));
			endcase
			if ($urandom_range(0, 4) == 0) begin
				c1 = $urandom();
				c0 = $urandom();
			end else begin
				// build the quadratic from two real roots inside the x range
				r1   = int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
				r2   = int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
				c1   = -(r1 + r2);
				prod = (longint'(r1) * r2) >>> COEF_FRAC;
				c0   = prod[31:0];
			end
			write_setting(iters, tol, c1, c0);
			for (int i = 0; i < 50; i++) begin
				if (i % 10 == 0)
					back_to_back = ($urandom_range(0, 3) == 0);
				if (i == 25 && phase % 4 == 1)
					wait_results_drained();
				if ($urandom_range(0, 99) < 85) begin
					for (int t = 0; t < 16; t++) begin
						lo = XW'(int'($urandom_range(0, 240 * 65536)) - 120 * 65536);
						hi = XW'(int'($urandom_range(0, 240 * 65536)) - 120 * 65536);
						if (lo > hi) begin
							tmp = lo;
							lo  = hi;
							hi  = tmp;
						end
						if (!same_sign(quad_value(longint'(lo)), quad_value(longint'(hi))))
							break;
					end
				end else begin
					lo = XW'($urandom());
					hi = XW'($urandom());
				end
				send_interval(lo, hi);
			end
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_limit_edges();
		test_exact_root();
		test_last_halving();
		test_coeff_extremes();
		test_random_roots();
		wait_results_drained();
		repeat (20) @(posedge clk);
		if (pending_roots.size() != 0) begin
			$error("%0d result words never arrived", pending_roots.size());
			mismatch_count++;
		end
		$display("bisection_root_finder_tb: %0d intervals searched, %0d result words checked",
		         items_sent, results_seen);
		$display("bisection_root_finder_tb: %0d register settings, %0d mismatches",
		         settings_written, mismatch_count);
		if (mismatch_count == 0)
			$display("bisection_root_finder_tb: PASS");
		else
			$display("bisection_root_finder_tb: FAIL");
		$finish;
	end

endmodule
